>>> rtl/pli_pkg.sv
// Package for the piecewise linear interpolator: codes, types and constants.
// Used by the interfaces, the controller, the datapath and the top level.
`default_nettype none

package pli_pkg;

    // Default number of breakpoint table entries.
    localparam int MAX_POINTS_DEF = 16;

    // Field widths fixed by the request and result formats.
    localparam int DATA_W  = 16;
    localparam int ENTRY_W = 4;
    localparam int COUNT_W = 5;

    // The quotient of one interpolation always fits in 16 bits.
    localparam int DIV_STEPS = 16;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Request operation codes.
    typedef enum logic {
        OP_EVAL = 1'b0,
        OP_LOAD = 1'b1
    } t_op;

    // Result region codes.
    typedef enum logic [1:0] {
        REGION_INTERP = 2'd0,
        REGION_LOW    = 2'd1,
        REGION_HIGH   = 2'd2,
        REGION_EMPTY  = 2'd3
    } t_region;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRIME,
        ST_SEARCH,
        ST_MUL,
        ST_DIV_SETUP,
        ST_DIV,
        ST_DIV_END,
        ST_FINISH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic prime;
        logic search;
        logic mul;
        logic div_setup;
        logic div_step;
        logic div_end;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_load;
        logic cnt_zero;
        logic gt;
        logic first;
        logic last;
        logic div_last;
    } t_status;

endpackage

`default_nettype wire

>>> rtl/pli_if.sv
// Request and result channel interfaces of the piecewise linear interpolator.
// Depends on pli_pkg for the field widths.
`default_nettype none

interface pli_req_if;
    logic                              valid;
    logic                              ready;
    logic                              operation;
    logic [pli_pkg::ENTRY_W-1:0]       entry_index;
    logic signed [pli_pkg::DATA_W-1:0] entry_x;
    logic signed [pli_pkg::DATA_W-1:0] entry_y;
    logic signed [pli_pkg::DATA_W-1:0] query_x;

    modport source (output valid, operation, entry_index, entry_x, entry_y, query_x,
                    input ready);
    modport sink   (input valid, operation, entry_index, entry_x, entry_y, query_x,
                    output ready);
endinterface

interface pli_rsp_if;
    logic                              valid;
    logic                              ready;
    logic signed [pli_pkg::DATA_W-1:0] value;
    logic [1:0]                        region;

    modport source (output valid, value, region, input ready);
    modport sink   (input valid, value, region, output ready);
endinterface

`default_nettype wire

>>> rtl/pli_datapath.sv
// Datapath of the piecewise linear interpolator: breakpoint memory, search
// registers, multiplier, restoring divider and output register. Uses pli_pkg.
`default_nettype none

module pli_datapath #(
    parameter int MAX_POINTS = pli_pkg::MAX_POINTS_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_wr_en,
    input  wire  [pli_pkg::COUNT_W-1:0]        i_cfg_wr_data,
    input  wire                                i_operation,
    input  wire  [pli_pkg::ENTRY_W-1:0]        i_entry_index,
    input  wire  signed [pli_pkg::DATA_W-1:0]  i_entry_x,
    input  wire  signed [pli_pkg::DATA_W-1:0]  i_entry_y,
    input  wire  signed [pli_pkg::DATA_W-1:0]  i_query_x,
    input  pli_pkg::t_cmd                      i_cmd,
    output pli_pkg::t_status                   o_status,
    output logic signed [pli_pkg::DATA_W-1:0]  o_value,
    output logic [1:0]                         o_region
);

    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int DW    = pli_pkg::DATA_W;

    // Configuration register.
    logic [pli_pkg::COUNT_W-1:0] r_points_in_use;

    // Breakpoint memory: y in the upper half, x in the lower half.
    logic [2*DW-1:0] r_mem [MAX_POINTS];
    logic [2*DW-1:0] r_rd_data;
    logic [IDX_W-1:0] r_addr;

    // Search state.
    logic [CNT_W-1:0]     r_n;
    logic [CNT_W-1:0]     r_chk;
    logic signed [DW-1:0] r_q;
    logic signed [DW-1:0] r_x0;
    logic signed [DW-1:0] r_y0;

    // Arithmetic state.
    logic signed [DW:0]     r_dy;
    logic signed [DW:0]     r_dx;
    logic [DW-1:0]          r_den;
    logic signed [2*DW+1:0] r_prod;
    logic                   r_neg;
    logic [DW-1:0]          r_rem;
    logic [DW-1:0]          r_quo;
    logic [pli_pkg::DIV_CNT_W-1:0] r_div_cnt;

    // Result staging and output register.
    logic signed [DW-1:0] r_res_value;
    logic [1:0]           r_res_region;
    logic signed [DW-1:0] r_out_value;
    logic [1:0]           r_out_region;

    logic signed [DW-1:0]   rd_x;
    logic signed [DW-1:0]   rd_y;
    logic [CNT_W-1:0]       cnt_sat;
    logic                   load_wr;
    logic [CNT_W-1:0]       chk_inc;
    logic [2*DW+1:0]        prod_mag;
    logic [DW:0]            div_shift;
    logic [DW:0]            div_sub;
    logic                   div_bit;
    logic signed [DW+1:0]   quo_signed;
    logic signed [DW+1:0]   res_sum;

    // Field split of the entry just read, and the saturated entry count.
    always_comb begin
        rd_x    = r_rd_data[DW-1:0];
        rd_y    = r_rd_data[2*DW-1:DW];
        cnt_sat = (int'(r_points_in_use) > MAX_POINTS) ? CNT_W'(MAX_POINTS)
                                                        : CNT_W'(r_points_in_use);
        load_wr = i_cmd.accept && (i_operation == pli_pkg::OP_LOAD) &&
                  (int'(i_entry_index) < MAX_POINTS);
        chk_inc = r_chk + CNT_W'(1);
    end

    // Status toward the controller.
    always_comb begin
        o_status.is_load  = (i_operation == pli_pkg::OP_LOAD);
        o_status.cnt_zero = (cnt_sat == '0);
        o_status.gt       = (rd_x > r_q);
        o_status.first    = (r_chk == '0);
        o_status.last     = (chk_inc == r_n);
        o_status.div_last = (r_div_cnt == pli_pkg::DIV_CNT_W'(pli_pkg::DIV_STEPS - 1));
    end

    // One restoring division step and the signed floor correction.
    always_comb begin
        prod_mag   = r_prod[2*DW+1] ? 34'(-r_prod) : 34'(r_prod);
        div_shift  = {r_rem, r_quo[DW-1]};
        div_sub    = div_shift - {1'b0, r_den};
        div_bit    = (div_shift >= {1'b0, r_den});
        quo_signed = r_neg ? (-(18'({2'b00, r_quo})) - 18'(r_rem != '0))
                           : 18'({2'b00, r_quo});
        res_sum    = 18'(r_y0) + quo_signed;
    end

    // Configuration register write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_points_in_use <= '0;
        end else if (i_cfg_wr_en) begin
            r_points_in_use <= i_cfg_wr_data;
        end
    end

    // Breakpoint memory with a registered read port.
    always_ff @(posedge i_clk) begin
        if (load_wr) begin
            r_mem[IDX_W'(i_entry_index)] <= {i_entry_y, i_entry_x};
        end
        r_rd_data <= r_mem[r_addr];
    end

    // Search, arithmetic and result registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_q    <= i_query_x;
            r_n    <= cnt_sat;
            r_addr <= '0;
            r_chk  <= '0;
            r_res_value <= '0;
            if (i_operation == pli_pkg::OP_LOAD) begin
                r_res_region <= pli_pkg::REGION_INTERP;
            end else begin
                r_res_region <= pli_pkg::REGION_EMPTY;
            end
        end

        if (i_cmd.prime) begin
            if (int'(r_addr) != MAX_POINTS - 1) begin
                r_addr <= r_addr + IDX_W'(1);
            end
        end

        if (i_cmd.search) begin
            if (o_status.gt) begin
                if (o_status.first) begin
                    r_res_value  <= rd_y;
                    r_res_region <= pli_pkg::REGION_LOW;
                end else begin
                    r_dy  <= 17'(rd_y) - 17'(r_y0);
                    r_dx  <= 17'(r_q) - 17'(r_x0);
                    r_den <= DW'(17'(rd_x) - 17'(r_x0));
                end
            end else begin
                r_x0 <= rd_x;
                r_y0 <= rd_y;
                if (o_status.last) begin
                    r_res_value  <= rd_y;
                    r_res_region <= pli_pkg::REGION_HIGH;
                end else begin
                    r_chk <= chk_inc;
                    if (int'(r_addr) != MAX_POINTS - 1) begin
                        r_addr <= r_addr + IDX_W'(1);
                    end
                end
            end
        end

        // Both factors are 17-bit signed; the product is sign extended to 34 bits.
        if (i_cmd.mul) begin
            r_prod <= 34'(r_dy) * 34'(r_dx);
        end

        // The magnitude is below 2^32 and its quotient below 2^16, so the
        // upper half starts as the partial remainder.
        if (i_cmd.div_setup) begin
            r_neg     <= r_prod[2*DW+1];
            r_rem     <= prod_mag[2*DW-1:DW];
            r_quo     <= prod_mag[DW-1:0];
            r_div_cnt <= '0;
        end

        if (i_cmd.div_step) begin
            r_rem     <= div_bit ? div_sub[DW-1:0] : div_shift[DW-1:0];
            r_quo     <= {r_quo[DW-2:0], div_bit};
            r_div_cnt <= r_div_cnt + pli_pkg::DIV_CNT_W'(1);
        end

        if (i_cmd.div_end) begin
            r_res_value  <= res_sum[DW-1:0];
            r_res_region <= pli_pkg::REGION_INTERP;
        end

        if (i_cmd.out_load) begin
            r_out_value  <= r_res_value;
            r_out_region <= r_res_region;
        end
    end

    assign o_value  = r_out_value;
    assign o_region = r_out_region;

endmodule

`default_nettype wire

>>> rtl/pli_ctrl.sv
// Controller state machine of the piecewise linear interpolator.
// Sequences the datapath through pli_pkg commands and owns the result valid.
`default_nettype none

module pli_ctrl (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  wire                    i_out_ready,
    input  pli_pkg::t_status       i_status,
    output pli_pkg::t_cmd          o_cmd
);

    pli_pkg::t_state r_state;
    pli_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;
    logic            accept;
    logic            out_free;

    always_comb begin
        accept   = i_in_valid && (r_state == pli_pkg::ST_IDLE);
        out_free = !r_out_valid || i_out_ready;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            pli_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_status.is_load || i_status.cnt_zero) begin
                        n_state = pli_pkg::ST_FINISH;
                    end else begin
                        n_state = pli_pkg::ST_PRIME;
                    end
                end
            end
            pli_pkg::ST_PRIME: begin
                n_state = pli_pkg::ST_SEARCH;
            end
            pli_pkg::ST_SEARCH: begin
                if (i_status.gt) begin
                    n_state = i_status.first ? pli_pkg::ST_FINISH : pli_pkg::ST_MUL;
                end else if (i_status.last) begin
                    n_state = pli_pkg::ST_FINISH;
                end
            end
            pli_pkg::ST_MUL: begin
                n_state = pli_pkg::ST_DIV_SETUP;
            end
            pli_pkg::ST_DIV_SETUP: begin
                n_state = pli_pkg::ST_DIV;
            end
            pli_pkg::ST_DIV: begin
                if (i_status.div_last) begin
                    n_state = pli_pkg::ST_DIV_END;
                end
            end
            pli_pkg::ST_DIV_END: begin
                n_state = pli_pkg::ST_FINISH;
            end
            pli_pkg::ST_FINISH: begin
                if (out_free) begin
                    n_state = pli_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pli_pkg::ST_IDLE;
            end
        endcase
    end

    // Commands and handshake outputs.
    always_comb begin
        o_cmd           = '0;
        o_cmd.accept    = accept;
        o_cmd.prime     = (r_state == pli_pkg::ST_PRIME);
        o_cmd.search    = (r_state == pli_pkg::ST_SEARCH);
        o_cmd.mul       = (r_state == pli_pkg::ST_MUL);
        o_cmd.div_setup = (r_state == pli_pkg::ST_DIV_SETUP);
        o_cmd.div_step  = (r_state == pli_pkg::ST_DIV);
        o_cmd.div_end   = (r_state == pli_pkg::ST_DIV_END);
        o_cmd.out_load  = (r_state == pli_pkg::ST_FINISH) && out_free;
        o_in_ready      = (r_state == pli_pkg::ST_IDLE);
        o_out_valid     = r_out_valid;
    end

    // Result valid: set when a result enters the output register, cleared when it is taken.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pli_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

>>> rtl/piecewise_linear_interpolator.sv
// Top level of the piecewise linear interpolator.
// Instantiates pli_ctrl and pli_datapath; uses pli_pkg and the pli_if interfaces.
//
// A load request writes one (x, y) breakpoint and an evaluate request returns
// the floored linear interpolation at query_x, or the clamped end ordinate.
// Requests are handled one at a time; a finished result waits in an output
// register, so the next request is taken while it is still pending. An
// evaluate with no points in use returns the empty region; otherwise the
// sequential search clamps low at the first entry, clamps high past the last
// point in use, or else interpolates by a multiply and a division. The search
// reads one memory entry per cycle from the single read port, and the division
// runs 16 restoring steps of a single divider.
`default_nettype none

module piecewise_linear_interpolator #(
    parameter int MAX_POINTS = pli_pkg::MAX_POINTS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_wr_en,
    input  wire  [pli_pkg::COUNT_W-1:0]  i_cfg_wr_data,
    pli_req_if.sink                      i_req,
    pli_rsp_if.source                    o_rsp
);

    pli_pkg::t_cmd    w_cmd;
    pli_pkg::t_status w_status;

    // Sequencing of each request.
    pli_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // Table, search and arithmetic.
    pli_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_operation   (i_req.operation),
        .i_entry_index (i_req.entry_index),
        .i_entry_x     (i_req.entry_x),
        .i_entry_y     (i_req.entry_y),
        .i_query_x     (i_req.query_x),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .o_value       (o_rsp.value),
        .o_region      (o_rsp.region)
    );

endmodule

`default_nettype wire
